### hdl/lfjc_pkg.sv
// ----------------------------------------------------------------------------
// lfjc_pkg: shared types and constants
// Payload structs, configuration layout, motion codes and phase encoding for
// the line-follow junction counter.
// ----------------------------------------------------------------------------
package lfjc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_JUNCTIONS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_CRUISE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_STEER         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_CRAWL         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_OFFSET_TICKS = 3'd4;

    // configuration reset values
    localparam logic [3:0]  RST_TARGET_JUNCTIONS  = 4'd3;
    localparam logic [7:0]  RST_SPD_CRUISE        = 8'd60;
    localparam logic [7:0]  RST_SPD_STEER         = 8'd45;
    localparam logic [7:0]  RST_SPD_CRAWL         = 8'd35;
    localparam logic [15:0] RST_STOP_OFFSET_TICKS = 16'd120;

    // input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // motion codes
    localparam logic [1:0] MV_STOP  = 2'd0;
    localparam logic [1:0] MV_FWD   = 2'd1;
    localparam logic [1:0] MV_LEFT  = 2'd2;
    localparam logic [1:0] MV_RIGHT = 2'd3;

    // sensor patterns {left, center, right}
    localparam logic [2:0] PAT_CENTER     = 3'b010;
    localparam logic [2:0] PAT_LEFT_MID   = 3'b110;
    localparam logic [2:0] PAT_LEFT       = 3'b100;
    localparam logic [2:0] PAT_MID_RIGHT  = 3'b011;
    localparam logic [2:0] PAT_RIGHT      = 3'b001;
    localparam logic [2:0] PAT_JUNCTION   = 3'b111;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_FOLLOW = 3'b010,
        PH_OFFSET = 3'b100
    } t_phase;

    typedef struct packed {
        logic action;
        logic dark_left;
        logic dark_center;
        logic dark_right;
        logic estop;
    } t_item;

    typedef struct packed {
        logic [3:0]  target_junctions;
        logic [7:0]  spd_cruise;
        logic [7:0]  spd_steer;
        logic [7:0]  spd_crawl;
        logic [15:0] stop_offset_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] motion;
        logic [7:0] speed;
        logic [3:0] junctions_seen;
        logic       finished;
        logic       succeeded;
    } t_result;

endpackage

### hdl/lfjc_cfg.sv
// ----------------------------------------------------------------------------
// lfjc_cfg: configuration register file
// Holds the five run settings; written through a plain indexed write port.
// ----------------------------------------------------------------------------
module lfjc_cfg
    import lfjc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_junctions  <= RST_TARGET_JUNCTIONS;
            r_cfg.spd_cruise        <= RST_SPD_CRUISE;
            r_cfg.spd_steer         <= RST_SPD_STEER;
            r_cfg.spd_crawl         <= RST_SPD_CRAWL;
            r_cfg.stop_offset_ticks <= RST_STOP_OFFSET_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TARGET_JUNCTIONS:  r_cfg.target_junctions  <= i_cfg_data[3:0];
                CFG_SPD_CRUISE:        r_cfg.spd_cruise        <= i_cfg_data[7:0];
                CFG_SPD_STEER:         r_cfg.spd_steer         <= i_cfg_data[7:0];
                CFG_SPD_CRAWL:         r_cfg.spd_crawl         <= i_cfg_data[7:0];
                CFG_STOP_OFFSET_TICKS: r_cfg.stop_offset_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/lfjc_in_reg.sv
// ----------------------------------------------------------------------------
// lfjc_in_reg: input register stage
// Captures one transaction and holds it until the decision stage takes it.
// ----------------------------------------------------------------------------
module lfjc_in_reg
    import lfjc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_stall,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // free when empty or when the held item leaves this cycle
    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### hdl/lfjc_ctrl.sv
// ----------------------------------------------------------------------------
// lfjc_ctrl: run state and steering decision
// Holds phase, junction count, junction latch and offset timer, and forms the
// result for the item presented in the input register.
// ----------------------------------------------------------------------------
module lfjc_ctrl
    import lfjc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_count, n_count;
    logic        r_on_junction, n_on_junction;
    logic [15:0] r_timer, n_timer;

    logic [2:0]  w_pat;
    logic [3:0]  w_count_inc;
    logic [1:0]  w_motion;
    logic [7:0]  w_speed;
    logic        w_finished;
    logic        w_succeeded;

    assign w_pat       = {i_item.dark_left, i_item.dark_center, i_item.dark_right};
    assign w_count_inc = r_count + 4'd1;

    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_on_junction = r_on_junction;
        n_timer       = r_timer;
        w_motion      = MV_STOP;
        w_speed       = 8'd0;
        w_finished    = 1'b0;
        w_succeeded   = 1'b0;

        if (i_item.action == ACT_START) begin
            n_count       = 4'd0;
            n_on_junction = 1'b1;
            n_timer       = 16'd0;
            if (i_cfg.target_junctions == 4'd0) begin
                n_phase    = PH_IDLE;
                w_finished = 1'b1;
            end else begin
                n_phase = PH_FOLLOW;
            end
        end else if (r_phase != PH_IDLE && i_item.estop) begin
            n_phase    = PH_IDLE;
            w_finished = 1'b1;
        end else begin
            unique case (r_phase)
                PH_FOLLOW: begin
                    if (w_pat == PAT_JUNCTION) begin
                        w_motion = MV_FWD;
                        w_speed  = i_cfg.spd_cruise;
                        if (!r_on_junction) begin
                            n_count       = w_count_inc;
                            n_on_junction = 1'b1;
                            if (w_count_inc >= i_cfg.target_junctions) begin
                                if (i_cfg.stop_offset_ticks == 16'd0) begin
                                    n_phase     = PH_IDLE;
                                    w_motion    = MV_STOP;
                                    w_finished  = 1'b1;
                                    w_succeeded = 1'b1;
                                end else begin
                                    n_phase = PH_OFFSET;
                                    n_timer = 16'd0;
                                end
                            end
                        end
                    end else begin
                        n_on_junction = 1'b0;
                        case (w_pat) inside
                            PAT_CENTER: begin
                                w_motion = MV_FWD;
                                w_speed  = i_cfg.spd_cruise;
                            end
                            PAT_LEFT_MID, PAT_LEFT: begin
                                w_motion = MV_LEFT;
                                w_speed  = i_cfg.spd_steer;
                            end
                            PAT_MID_RIGHT, PAT_RIGHT: begin
                                w_motion = MV_RIGHT;
                                w_speed  = i_cfg.spd_steer;
                            end
                            default: begin
                                w_motion = MV_FWD;
                                w_speed  = i_cfg.spd_crawl;
                            end
                        endcase
                    end
                end
                PH_OFFSET: begin
                    if (r_timer >= i_cfg.stop_offset_ticks) begin
                        n_phase     = PH_IDLE;
                        w_finished  = 1'b1;
                        w_succeeded = 1'b1;
                    end else begin
                        n_timer  = r_timer + 16'd1;
                        w_motion = MV_FWD;
                        w_speed  = i_cfg.spd_cruise;
                    end
                end
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_count       <= 4'd0;
            r_on_junction <= 1'b1;
            r_timer       <= 16'd0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_count       <= n_count;
            r_on_junction <= n_on_junction;
            r_timer       <= n_timer;
        end
    end

    // speed reads zero whenever the wheels are stopped
    assign o_result.motion         = w_motion;
    assign o_result.speed          = (w_motion == MV_STOP) ? 8'd0 : w_speed;
    assign o_result.junctions_seen = n_count;
    assign o_result.finished       = w_finished;
    assign o_result.succeeded      = w_succeeded;

endmodule

### hdl/lfjc_out_reg.sv
// ----------------------------------------------------------------------------
// lfjc_out_reg: result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module lfjc_out_reg
    import lfjc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### hdl/line_follow_junction_counter_top.sv
// Path: an accepted input transaction is held in the input register, then the
// decision logic loads its result into the result register once that has room.
// Throughput: one transaction per cycle; the only limit is downstream stall.
// Reset: synchronous, active low; clears the run state to idle with the
// junction latch set and loads the default speeds, target and stop offset.
// ----------------------------------------------------------------------------
// line_follow_junction_counter_top: line-follow controller with junction count
// Steers a three-sensor line follower, counts junctions, drives on for a
// programmable number of ticks after the last one and reports the outcome.
// ----------------------------------------------------------------------------
module line_follow_junction_counter_top
    import lfjc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    // input transaction channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic                  i_dark_left,
    input  logic                  i_dark_center,
    input  logic                  i_dark_right,
    input  logic                  i_estop,

    // result transaction channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_motion,
    output logic [7:0]            o_speed,
    output logic [3:0]            o_junctions_seen,
    output logic                  o_finished,
    output logic                  o_succeeded
);

    t_cfg    w_cfg;
    t_item   w_in_item;
    t_item   w_held_item;
    logic    w_held_valid;
    logic    w_out_free;
    logic    w_fire;
    t_result w_result;
    t_result w_out_result;

    assign w_in_item.action      = i_action;
    assign w_in_item.dark_left   = i_dark_left;
    assign w_in_item.dark_center = i_dark_center;
    assign w_in_item.dark_right  = i_dark_right;
    assign w_in_item.estop       = i_estop;

    // The held item is decided, and the run state advances, in the cycle the
    // result register has room for it.
    assign w_fire = w_held_valid && w_out_free;

    lfjc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Input stage: capture the transaction; stall only while a held item
    // cannot move on.
    lfjc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (w_in_item),
        .o_stall (o_in_stall),
        .i_take  (w_fire),
        .o_valid (w_held_valid),
        .o_item  (w_held_item)
    );

    // Decision stage: phase, junction counting, steering and the offset drive.
    lfjc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_held_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Result stage: hold the result while downstream stalls.
    lfjc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_result),
        .o_free   (w_out_free),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (w_out_result)
    );

    assign o_motion         = w_out_result.motion;
    assign o_speed          = w_out_result.speed;
    assign o_junctions_seen = w_out_result.junctions_seen;
    assign o_finished       = w_out_result.finished;
    assign o_succeeded      = w_out_result.succeeded;

endmodule

### hdl/lfjc_checker.sv
// ----------------------------------------------------------------------------
// lfjc_checker: port-level checks for the junction counter
// Watches result transactions for consistent outcome and motion fields.
// ----------------------------------------------------------------------------
module lfjc_checker
    import lfjc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_stall,
    input logic [1:0] i_motion,
    input logic [7:0] i_speed,
    input logic       i_finished,
    input logic       i_succeeded
);

    // a stopped robot reports speed zero
    a_stop_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_motion == MV_STOP) |-> (i_speed == 8'd0))
        else $error("speed nonzero while stopped");

    // success is only reported on the transaction that ends the run
    a_success_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_succeeded) |-> i_finished)
        else $error("succeeded without finished");

    // the ending transaction always stops the wheels
    a_finish_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_finished) |-> (i_motion == MV_STOP))
        else $error("run finished while still moving");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=>
            (i_out_valid && $stable(i_motion) && $stable(i_speed)
             && $stable(i_finished) && $stable(i_succeeded)))
        else $error("stalled result changed");

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind line_follow_junction_counter_top lfjc_checker u_lfjc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_motion    (o_motion),
    .i_speed     (o_speed),
    .i_finished  (o_finished),
    .i_succeeded (o_succeeded)
);

### tb/sv/line_follow_junction_counter_top_tb.sv
// ----------------------------------------------------------------------------
// line_follow_junction_counter_top_tb: self-checking bench for the controller
// Drives start and tick transactions through the valid/stall input channel,
// predicts each result transaction with a cycle-free model of the steering,
// junction counting, offset drive and emergency stop, and compares every
// field of every result. Runs a directed opening, then random runs across
// several register settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module line_follow_junction_counter_top_tb;
    import lfjc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 800_000;
    localparam int unsigned PHASE_ITEMS  = 200;
    localparam int unsigned RANDOM_SETS  = 10;
    localparam int unsigned MAX_PRINTED  = 20;

    // DUT inputs start known from time zero
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  i_action       = 1'b0;
    logic                  i_dark_left    = 1'b0;
    logic                  i_dark_center  = 1'b0;
    logic                  i_dark_right   = 1'b0;
    logic                  i_estop        = 1'b0;
    logic                  i_out_stall    = 1'b0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [1:0]            o_motion;
    logic [7:0]            o_speed;
    logic [3:0]            o_junctions_seen;
    logic                  o_finished;
    logic                  o_succeeded;

    line_follow_junction_counter_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_dark_left      (i_dark_left),
        .i_dark_center    (i_dark_center),
        .i_dark_right     (i_dark_right),
        .i_estop          (i_estop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_motion         (o_motion),
        .o_speed          (o_speed),
        .o_junctions_seen (o_junctions_seen),
        .o_finished       (o_finished),
        .o_succeeded      (o_succeeded)
    );

    // 20-unit clock period
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------------
    // Stimulus and result bookkeeping
    // ------------------------------------------------------------------------
    t_item       pending_items[$];   // transactions waiting for the driver
    t_result     expected_results[$];// predicted results, oldest first
    t_item       next_item;
    int          gap_left    = 0;
    int          stall_left  = 0;
    bit          no_idle     = 1'b0; // stretches with neither gaps nor stalls
    int unsigned cycle_count = 0;
    int unsigned n_queued    = 0;
    int unsigned n_checked   = 0;
    int unsigned n_errors    = 0;
    int unsigned n_settings  = 0;

    // ------------------------------------------------------------------------
    // Controller model: shadow registers and run state
    // ------------------------------------------------------------------------
    t_cfg        cfg_shadow;
    t_phase      run_phase;
    logic [3:0]  junc_count;
    logic        on_junc;
    logic [15:0] offset_ticks;
    int unsigned n_starts    = 0;
    int unsigned n_completed = 0;
    int unsigned n_aborted   = 0;
    int unsigned peak_count  = 0;

    initial begin
        cfg_shadow.target_junctions  = RST_TARGET_JUNCTIONS;
        cfg_shadow.spd_cruise        = RST_SPD_CRUISE;
        cfg_shadow.spd_steer         = RST_SPD_STEER;
        cfg_shadow.spd_crawl         = RST_SPD_CRAWL;
        cfg_shadow.stop_offset_ticks = RST_STOP_OFFSET_TICKS;
        run_phase    = PH_IDLE;
        junc_count   = '0;
        on_junc      = 1'b1;
        offset_ticks = '0;
    end

    function automatic t_result drive_cmd(logic [1:0] mv, logic [7:0] spd,
                                          logic fin, logic ok);
        t_result r;
        r.motion         = mv;
        r.speed          = (mv == MV_STOP) ? 8'd0 : spd;
        r.junctions_seen = junc_count;
        r.finished       = fin;
        r.succeeded      = ok;
        return r;
    endfunction

    // Advance the model by one transaction and return the command it answers with.
    function automatic t_result follow_step(t_item it);
        logic [2:0] pat;
        pat = {it.dark_left, it.dark_center, it.dark_right};

        // start: clear the count, stand on a junction, estop ignored
        if (it.action == ACT_START) begin
            junc_count   = '0;
            on_junc      = 1'b1;
            offset_ticks = '0;
            n_starts++;
            if (cfg_shadow.target_junctions == 4'd0) begin
                run_phase = PH_IDLE;
                n_aborted++;
                return drive_cmd(MV_STOP, 8'd0, 1'b1, 1'b0);
            end
            run_phase = PH_FOLLOW;
            return drive_cmd(MV_STOP, 8'd0, 1'b0, 1'b0);
        end

        // emergency stop aborts a live run; an idle controller ignores it
        if (run_phase != PH_IDLE && it.estop) begin
            run_phase = PH_IDLE;
            n_aborted++;
            return drive_cmd(MV_STOP, 8'd0, 1'b1, 1'b0);
        end

        if (run_phase == PH_FOLLOW) begin
            if (pat == PAT_JUNCTION) begin
                // count only after leaving the previous junction
                if (!on_junc) begin
                    junc_count = junc_count + 4'd1;
                    on_junc    = 1'b1;
                    if (junc_count > peak_count)
                        peak_count = junc_count;
                    if (junc_count >= cfg_shadow.target_junctions) begin
                        if (cfg_shadow.stop_offset_ticks == 16'd0) begin
                            run_phase = PH_IDLE;
                            n_completed++;
                            return drive_cmd(MV_STOP, 8'd0, 1'b1, 1'b1);
                        end
                        run_phase    = PH_OFFSET;
                        offset_ticks = '0;
                    end
                end
                return drive_cmd(MV_FWD, cfg_shadow.spd_cruise, 1'b0, 1'b0);
            end
            on_junc = 1'b0;
            case (pat)
                PAT_CENTER:
                    return drive_cmd(MV_FWD, cfg_shadow.spd_cruise, 1'b0, 1'b0);
                PAT_LEFT_MID, PAT_LEFT:
                    return drive_cmd(MV_LEFT, cfg_shadow.spd_steer, 1'b0, 1'b0);
                PAT_MID_RIGHT, PAT_RIGHT:
                    return drive_cmd(MV_RIGHT, cfg_shadow.spd_steer, 1'b0, 1'b0);
                default:
                    return drive_cmd(MV_FWD, cfg_shadow.spd_crawl, 1'b0, 1'b0);
            endcase
        end

        // drive on past the last junction, then stop with success
        if (run_phase == PH_OFFSET) begin
            if (offset_ticks >= cfg_shadow.stop_offset_ticks) begin
                run_phase = PH_IDLE;
                n_completed++;
                return drive_cmd(MV_STOP, 8'd0, 1'b1, 1'b1);
            end
            offset_ticks = offset_ticks + 16'd1;
            return drive_cmd(MV_FWD, cfg_shadow.spd_cruise, 1'b0, 1'b0);
        end

        return drive_cmd(MV_STOP, 8'd0, 1'b0, 1'b0);
    endfunction

    // ------------------------------------------------------------------------
    // Error reporting and comparison
    // ------------------------------------------------------------------------
    task automatic report_error(string msg);
        if (n_errors < MAX_PRINTED)
            $display("[%0t] ERROR: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_error($sformatf("result %0d: %s is %0d, expected %0d",
                                   n_checked, name, got, want));
    endtask

    // Random idle length: mostly none or short, a few long.
    function automatic int pick_idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: predict on acceptance, then present the next transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(follow_step(
                    '{action: i_action, dark_left: i_dark_left,
                      dark_center: i_dark_center, dark_right: i_dark_right,
                      estop: i_estop}));
            end
            // the slot is free when nothing is shown or the shown one just went
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    i_in_valid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    i_in_valid     <= 1'b1;
                    i_action       <= next_item.action;
                    i_dark_left    <= next_item.dark_left;
                    i_dark_center  <= next_item.dark_center;
                    i_dark_right   <= next_item.dark_right;
                    i_estop        <= next_item.estop;
                    gap_left       <= pick_idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check accepted results, stall the output at random
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_error($sformatf("unexpected result transaction, motion %0d",
                                           o_motion));
                end else begin
                    want = expected_results.pop_front();
                    check_field("motion", o_motion, want.motion);
                    check_field("speed", o_speed, want.speed);
                    check_field("junctions_seen", o_junctions_seen, want.junctions_seen);
                    check_field("finished", o_finished, want.finished);
                    check_field("succeeded", o_succeeded, want.succeeded);
                end
                n_checked++;
            end
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left  <= stall_left - 1;
            end else begin
                // a fresh stall burst starts with this cycle
                int len;
                len = pick_idle_len();
                i_out_stall <= (len != 0);
                stall_left  <= (len != 0) ? len - 1 : 0;
            end
        end
    end

    // Hard limit on run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(logic act, logic [2:0] pat, logic stop_req);
        t_item it;
        it.action      = act;
        it.dark_left   = pat[2];
        it.dark_center = pat[1];
        it.dark_right  = pat[0];
        it.estop       = stop_req;
        pending_items.push_back(it);
        n_queued++;
    endtask

    // Start with random sensors and a random (ignored) estop.
    task automatic push_start();
        push_item(ACT_START, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endtask

    // Tick with a rare emergency stop.
    task automatic push_tick(logic [2:0] pat);
        push_item(ACT_TICK, pat, $urandom_range(0, 199) == 0);
    endtask

    // Wait until every transaction is in and every result is out.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TARGET_JUNCTIONS:  cfg_shadow.target_junctions  = val[3:0];
            CFG_SPD_CRUISE:        cfg_shadow.spd_cruise        = val[7:0];
            CFG_SPD_STEER:         cfg_shadow.spd_steer         = val[7:0];
            CFG_SPD_CRAWL:         cfg_shadow.spd_crawl         = val[7:0];
            CFG_STOP_OFFSET_TICKS: cfg_shadow.stop_offset_ticks = val;
            default: ;
        endcase
    endtask

    // Drain, then load a full register setting; the run state carries over.
    task automatic load_setting(logic [3:0] tgt, logic [7:0] fwd, logic [7:0] turn,
                                logic [7:0] slow, logic [15:0] offs);
        wait_drained();
        write_reg(CFG_TARGET_JUNCTIONS, 16'(tgt));
        write_reg(CFG_SPD_CRUISE, 16'(fwd));
        write_reg(CFG_SPD_STEER, 16'(turn));
        write_reg(CFG_SPD_CRAWL, 16'(slow));
        write_reg(CFG_STOP_OFFSET_TICKS, offs);
        n_settings++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_speed();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            return 8'd0;
        if (roll < 4)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Sensor pattern between junctions: mostly centered, some drift, some noise.
    function automatic logic [2:0] pick_line_pattern();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 3'($urandom_range(0, 7));
        if (roll < 55)
            return PAT_CENTER;
        return 3'($urandom_range(0, 6));
    endfunction

    // One run: start, line following with one junction group more than the
    // target, then ticks for the offset (at most ten) plus one to three more.
    task automatic queue_run();
        int segs;
        int tail;
        push_start();
        segs = int'(cfg_shadow.target_junctions) + 1;
        for (int s = 0; s < segs; s++) begin
            repeat ($urandom_range(1, 5))
                push_tick(pick_line_pattern());
            if ($urandom_range(0, 49) == 0)
                push_start();
            repeat ($urandom_range(1, 3))
                push_tick(PAT_JUNCTION);
        end
        tail = (cfg_shadow.stop_offset_ticks > 10) ? 10 : int'(cfg_shadow.stop_offset_ticks);
        repeat (tail + $urandom_range(1, 3))
            push_tick(pick_line_pattern());
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [3:0]  tgt;
        logic [15:0] offs;
        int unsigned mark;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, default registers: idle ticks, estop on idle and on start,
        // every sensor pattern, the held junction, a count, then an abort.
        push_tick(3'b000);
        push_item(ACT_TICK, PAT_JUNCTION, 1'b1);
        push_item(ACT_START, PAT_JUNCTION, 1'b1);
        push_item(ACT_TICK, PAT_JUNCTION, 1'b0);
        push_item(ACT_TICK, PAT_CENTER, 1'b0);
        push_item(ACT_TICK, PAT_LEFT_MID, 1'b0);
        push_item(ACT_TICK, PAT_LEFT, 1'b0);
        push_item(ACT_TICK, PAT_MID_RIGHT, 1'b0);
        push_item(ACT_TICK, PAT_RIGHT, 1'b0);
        push_item(ACT_TICK, 3'b000, 1'b0);
        push_item(ACT_TICK, 3'b101, 1'b0);
        push_item(ACT_TICK, PAT_JUNCTION, 1'b0);
        push_item(ACT_TICK, PAT_JUNCTION, 1'b0);
        push_item(ACT_TICK, PAT_CENTER, 1'b1);
        push_item(ACT_TICK, PAT_CENTER, 1'b0);

        // One junction, no offset: success on the junction itself.
        load_setting(4'd1, 8'd255, 8'd0, 8'd255, 16'd0);
        push_item(ACT_START, 3'b000, 1'b0);
        push_item(ACT_TICK, PAT_CENTER, 1'b0);
        push_item(ACT_TICK, PAT_JUNCTION, 1'b0);

        // Two offset ticks, then success.
        load_setting(4'd1, 8'd0, 8'd255, 8'd0, 16'd2);
        push_item(ACT_START, 3'b111, 1'b0);
        push_item(ACT_TICK, 3'b000, 1'b0);
        push_item(ACT_TICK, PAT_JUNCTION, 1'b0);
        push_item(ACT_TICK, PAT_CENTER, 1'b0);
        push_item(ACT_TICK, PAT_CENTER, 1'b0);
        push_item(ACT_TICK, PAT_CENTER, 1'b0);

        // Zero target: a start ends the run at once.
        load_setting(4'd0, 8'd60, 8'd45, 8'd35, 16'd120);
        push_item(ACT_START, 3'b000, 1'b0);

        // Random settings; each change waits for the pipeline to empty, which
        // also holds the sender until every result is back.
        for (int p = 0; p < RANDOM_SETS; p++) begin
            case ($urandom_range(0, 4))
                0:       tgt = 4'd1;
                1:       tgt = 4'd15;
                default: tgt = 4'($urandom_range(1, 15));
            endcase
            if (p == 6)
                tgt = 4'd0;
            case ($urandom_range(0, 9))
                0, 1, 2: offs = 16'd0;
                3, 4:    offs = 16'($urandom_range(7, 40));
                default: offs = 16'($urandom_range(1, 6));
            endcase
            // longest offset, left unfinished so the next setting cuts it short
            if (p == 4)
                offs = 16'hFFFF;
            load_setting(tgt, pick_speed(), pick_speed(), pick_speed(), offs);
            no_idle = (p == 2) || ($urandom_range(0, 5) == 0);
            mark = n_queued;
            while (n_queued - mark < PHASE_ITEMS)
                queue_run();
        end

        wait_drained();
        repeat (10) @(negedge i_clk);

        $display("Checked %0d result transactions from %0d inputs over %0d register settings.",
                 n_checked, n_queued, n_settings + 1);
        $display("Runs: %0d started, %0d reached target, %0d aborted; peak count %0d.",
                 n_starts, n_completed, n_aborted, peak_count);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### line_follow_junction_counter_top.f
hdl/lfjc_pkg.sv
hdl/lfjc_cfg.sv
hdl/lfjc_in_reg.sv
hdl/lfjc_ctrl.sv
hdl/lfjc_out_reg.sv
hdl/line_follow_junction_counter_top.sv
hdl/lfjc_checker.sv
tb/sv/line_follow_junction_counter_top_tb.sv
